@@ hw/rtl/integer_to_roman_numeral_top_macros.svh @@
// Assertion macros for the integer-to-Roman-numeral block.
`ifndef INTEGER_TO_ROMAN_NUMERAL_TOP_MACROS_SVH
`define INTEGER_TO_ROMAN_NUMERAL_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on aclk, off during reset
`define I2R_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("i2r assertion failed");

// Next-cycle implication, checked on aclk, off during reset
`define I2R_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("i2r assertion failed");

`else

`define I2R_ASSERT_NOW(label, ante, cons)
`define I2R_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ hw/rtl/i2r_pkg.sv @@
// Shared types, constants and symbol tables for the Roman numeral converter.
package i2r_pkg;

    localparam logic [11:0] VALUE_LIMIT = 12'd3999;
    localparam int unsigned NUM_POS     = 4;

    localparam logic [7:0] ASCII_M = 8'h4D;
    localparam logic [7:0] ASCII_D = 8'h44;
    localparam logic [7:0] ASCII_C = 8'h43;
    localparam logic [7:0] ASCII_L = 8'h4C;
    localparam logic [7:0] ASCII_X = 8'h58;
    localparam logic [7:0] ASCII_V = 8'h56;
    localparam logic [7:0] ASCII_I = 8'h49;

    typedef enum logic [1:0] {
        SYM_ONE,
        SYM_FIVE,
        SYM_TEN
    } i2r_sym_kind_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic conv;
        logic start_emit;
        logic emit;
        logic emit_err;
    } i2r_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic oor;
        logic conv_last;
        logic numeral_empty;
        logic out_free;
        logic char_last;
    } i2r_sts_t;

    // characters needed for one decimal digit
    function automatic logic [2:0] digit_len(input logic [3:0] d);
        unique case (d) inside
            4'd1, 4'd5:       return 3'd1;
            4'd2, 4'd4, 4'd6,
            4'd9:             return 3'd2;
            4'd3, 4'd7:       return 3'd3;
            4'd8:             return 3'd4;
            default:          return 3'd0;
        endcase
    endfunction

    // which symbol sits at character idx of digit d
    function automatic i2r_sym_kind_t char_kind(input logic [3:0] d, input logic [1:0] idx);
        i2r_sym_kind_t k;
        k = SYM_ONE;
        if (d == 4'd4) begin
            k = (idx == 2'd0) ? SYM_ONE : SYM_FIVE;
        end else if (d == 4'd9) begin
            k = (idx == 2'd0) ? SYM_ONE : SYM_TEN;
        end else if (d >= 4'd5) begin
            k = (idx == 2'd0) ? SYM_FIVE : SYM_ONE;
        end
        return k;
    endfunction

    // ASCII code for a symbol kind at a decimal position (0 = units)
    function automatic logic [7:0] sym_code(input logic [1:0] pos, input i2r_sym_kind_t kind);
        logic [7:0] c;
        c = 8'd0;
        unique case (pos)
            2'd3: c = (kind == SYM_ONE) ? ASCII_M : 8'd0;
            2'd2: c = (kind == SYM_ONE) ? ASCII_C : (kind == SYM_FIVE) ? ASCII_D : ASCII_M;
            2'd1: c = (kind == SYM_ONE) ? ASCII_X : (kind == SYM_FIVE) ? ASCII_L : ASCII_C;
            default: c = (kind == SYM_ONE) ? ASCII_I : (kind == SYM_FIVE) ? ASCII_V : ASCII_X;
        endcase
        return c;
    endfunction

    // k times the weight of a decimal position
    function automatic logic [13:0] step_amt(input logic [1:0] pos, input logic [3:0] k);
        logic [13:0] w;
        unique case (pos)
            2'd3:    w = 14'd1000;
            2'd2:    w = 14'd100;
            2'd1:    w = 14'd10;
            default: w = 14'd1;
        endcase
        return 14'({10'd0, k} * w);
    endfunction

endpackage

@@ hw/rtl/i2r_dp.sv @@
// Datapath: digit extraction, digit store, character selection and output word register.
module i2r_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [11:0]        s_value,
    input  i2r_pkg::i2r_cmd_t  cmd,
    output i2r_pkg::i2r_sts_t  sts,
    input  logic               m_ready,
    output logic               m_valid,
    output logic [7:0]         m_symbol,
    output logic               m_last,
    output logic               m_out_of_range
);
    import i2r_pkg::*;

    logic [11:0] rem_reg, rem_next;
    logic [1:0]  cpos_reg, cpos_next;
    logic [3:0]  dig_reg  [NUM_POS];
    logic [3:0]  dig_next [NUM_POS];
    logic [1:0]  epos_reg, epos_next;
    logic [1:0]  idx_reg, idx_next;
    logic        oor_reg, oor_next;

    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_symbol_reg, m_symbol_next;
    logic        m_last_reg, m_last_next;
    logic        m_oor_reg, m_oor_next;

    logic [3:0]  conv_digit;
    logic [11:0] conv_rem;
    logic [3:0]  cur_dig;
    logic [2:0]  cur_len;
    logic        dig_end;
    logic        lower_any, first_any;
    logic [1:0]  lower_pos, first_pos;

    // digit at cpos = number of multiples of its weight not above the remainder
    always_comb begin
        conv_digit = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if ({2'b00, rem_reg} >= step_amt(cpos_reg, 4'(k))) begin
                conv_digit = conv_digit + 4'd1;
            end
        end
        conv_rem = 12'({2'b00, rem_reg} - step_amt(cpos_reg, conv_digit));
    end

    assign cur_dig = dig_reg[epos_reg];
    assign cur_len = digit_len(cur_dig);
    assign dig_end = (({1'b0, idx_reg} + 3'd1) == cur_len);

    // highest non-zero digit overall and below the one being emitted
    always_comb begin
        lower_any = 1'b0;
        lower_pos = 2'd0;
        first_any = 1'b0;
        first_pos = 2'd0;
        for (int q = 0; q < NUM_POS; q++) begin
            if (dig_reg[q] != 4'd0) begin
                first_any = 1'b1;
                first_pos = 2'(q);
                if (2'(q) < epos_reg) begin
                    lower_any = 1'b1;
                    lower_pos = 2'(q);
                end
            end
        end
    end

    always_comb begin
        rem_next  = rem_reg;
        cpos_next = cpos_reg;
        dig_next  = dig_reg;
        epos_next = epos_reg;
        idx_next  = idx_reg;
        oor_next  = oor_reg;
        if (cmd.load) begin
            rem_next  = s_value;
            cpos_next = 2'd3;
            oor_next  = (s_value > VALUE_LIMIT);
        end
        if (cmd.conv) begin
            dig_next[cpos_reg] = conv_digit;
            rem_next           = conv_rem;
            cpos_next          = cpos_reg - 2'd1;
        end
        if (cmd.start_emit) begin
            epos_next = first_pos;
            idx_next  = 2'd0;
        end
        if (cmd.emit) begin
            if (dig_end) begin
                epos_next = lower_pos;
                idx_next  = 2'd0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_symbol_next = m_symbol_reg;
        m_last_next   = m_last_reg;
        m_oor_next    = m_oor_reg;
        if (cmd.emit) begin
            m_valid_next  = 1'b1;
            m_symbol_next = sym_code(epos_reg, char_kind(cur_dig, idx_reg));
            m_last_next   = dig_end && !lower_any;
            m_oor_next    = 1'b0;
        end else if (cmd.emit_err) begin
            m_valid_next  = 1'b1;
            m_symbol_next = 8'd0;
            m_last_next   = 1'b1;
            m_oor_next    = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        cpos_reg     <= cpos_next;
        dig_reg      <= dig_next;
        epos_reg     <= epos_next;
        idx_reg      <= idx_next;
        oor_reg      <= oor_next;
        m_symbol_reg <= m_symbol_next;
        m_last_reg   <= m_last_next;
        m_oor_reg    <= m_oor_next;
    end

    assign sts.oor           = oor_reg;
    assign sts.conv_last     = (cpos_reg == 2'd0);
    assign sts.numeral_empty = !first_any;
    assign sts.out_free      = !m_valid_reg || m_ready;
    assign sts.char_last     = dig_end && !lower_any;

    assign m_valid        = m_valid_reg;
    assign m_symbol       = m_symbol_reg;
    assign m_last         = m_last_reg;
    assign m_out_of_range = m_oor_reg;

`include "integer_to_roman_numeral_top_macros.svh"

    `I2R_ASSERT_NOW(a_err_is_last, m_valid_reg && m_oor_reg, m_last_reg)
    `I2R_ASSERT_NEXT(a_units_clear, cmd.conv && (cpos_reg == 2'd0), rem_reg == 12'd0)
    `I2R_ASSERT_NOW(a_emit_in_range, cmd.emit, !oor_reg)

endmodule

@@ hw/rtl/i2r_ctrl.sv @@
// Controller: sequences load, digit conversion and character emission.
module i2r_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  i2r_pkg::i2r_sts_t  sts,
    output i2r_pkg::i2r_cmd_t  cmd
);
    import i2r_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_ERR   = 3'd4;

    logic [2:0] state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (sts.oor) begin
                    state_next = ST_ERR;
                end else begin
                    cmd.conv = 1'b1;
                    if (sts.conv_last) begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                if (sts.numeral_empty) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.start_emit = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.char_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR: begin
                if (sts.out_free) begin
                    cmd.emit_err = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`include "integer_to_roman_numeral_top_macros.svh"

    `I2R_ASSERT_NOW(a_emit_when_free, cmd.emit || cmd.emit_err, sts.out_free)
    `I2R_ASSERT_NEXT(a_err_to_idle, cmd.emit_err, state_reg == ST_IDLE)
    `I2R_ASSERT_NEXT(a_load_to_conv, cmd.load, state_reg == ST_CONV)

endmodule

@@ hw/rtl/integer_to_roman_numeral_top.sv @@
// Integer to Roman numeral converter: takes a 12-bit unsigned value on the
// s_ channel and returns its Roman numeral on the m_ channel as a run of
// ASCII words (M D C L X V I), most significant first, with m_last on the
// final word. Zero gives no words at all. A value above 3999 gives a single
// word with m_symbol zero, m_last set and m_out_of_range set. One value is
// handled at a time: after acceptance the four decimal digits are worked
// out one per cycle (thousands down to units), a start step picks the first
// non-zero digit, and then one character leaves per cycle while m_ready is
// high. A value spells out to at most 15 characters (3888), and s_ready
// stays low until its last word, if any, is loaded into the output register.
// The output register decouples the two sides, so the next value is taken
// while the last word of the previous one still waits for the consumer.
module integer_to_roman_numeral_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [11:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_symbol,
    output logic        m_last,
    output logic        m_out_of_range
);
    import i2r_pkg::*;

    i2r_cmd_t cmd;   // controller commands
    i2r_sts_t sts;   // datapath status

    // state machine: load, per-digit conversion, emission
    i2r_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // remainder, digit store, symbol mux and output word register
    i2r_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_value        (s_value),
        .cmd            (cmd),
        .sts            (sts),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_symbol       (m_symbol),
        .m_last         (m_last),
        .m_out_of_range (m_out_of_range)
    );

endmodule

@@ test/tb_integer_to_roman_numeral_top.sv @@
// Self-checking testbench for the integer-to-Roman-numeral converter.
`timescale 1ns / 100ps

module tb_integer_to_roman_numeral_top;

    import i2r_pkg::*;

    // ------------------------------------------------------------------
    // Timing and run-length figures
    // ------------------------------------------------------------------
    localparam int HALF_PERIOD  = 10;    // 20 ns clock
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 300;
    localparam int DRAIN_EVERY  = 100;   // sender holds off until all words are in
    // Quiet spell once the last expected word has gone by, long enough for the
    // block to finish any value, so that stray words would show.
    localparam int SETTLE_CYCLES = 64;
    // Longest correct stretch with no handshake on either side: the longest
    // sender gap, the digit stepping, and a receiver that is ready with a
    // chance of one in eight. Take it many times over.
    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 40;
    localparam int DIR_ROWS     = 24;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
        logic       oor;
    } roman_word_t;

    // How a directed row is checked: spelled out by hand, a range error,
    // or worked out by the predictor
    typedef enum logic [1:0] {
        ROW_TYPED,
        ROW_RANGE,
        ROW_MODEL
    } row_kind_t;

    // Receiver back-pressure patterns
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_SPARSE,
        RX_BEAT
    } rx_mode_t;

    // Symbol codes per decimal position, units first
    localparam logic [7:0] UNIT_CODE [4] = '{ASCII_I, ASCII_X, ASCII_C, ASCII_M};
    localparam logic [7:0] FIVE_CODE [4] = '{ASCII_V, ASCII_L, ASCII_D, 8'd0};
    localparam logic [7:0] TEN_CODE  [4] = '{ASCII_X, ASCII_C, ASCII_M, 8'd0};
    localparam int unsigned PLACE    [4] = '{1, 10, 100, 1000};

    // ------------------------------------------------------------------
    // Directed table: extremes, a spread of digit shapes across the positions, range
    // errors. Hand-typed numerals only where they are obvious.
    // ------------------------------------------------------------------
    logic [11:0] dir_value [DIR_ROWS] = '{
        12'd0,    12'd1,    12'd3999, 12'd3888, 12'd4000, 12'd4095,
        12'd4,    12'd9,    12'd5,    12'd8,    12'd40,   12'd90,
        12'd400,  12'd900,  12'd1000, 12'd3000, 12'd2,    12'd7,
        12'd44,   12'd99,   12'd1994, 12'd2048, 12'd3449, 12'd10
    };
    row_kind_t dir_kind [DIR_ROWS] = '{
        ROW_TYPED, ROW_TYPED, ROW_TYPED, ROW_TYPED, ROW_RANGE, ROW_RANGE,
        ROW_MODEL, ROW_MODEL, ROW_MODEL, ROW_MODEL, ROW_MODEL, ROW_MODEL,
        ROW_MODEL, ROW_MODEL, ROW_MODEL, ROW_MODEL, ROW_MODEL, ROW_MODEL,
        ROW_MODEL, ROW_MODEL, ROW_MODEL, ROW_MODEL, ROW_MODEL, ROW_MODEL
    };
    string dir_text [DIR_ROWS] = '{
        "", "I", "MMMCMXCIX", "MMMDCCCLXXXVIII", "", "",
        "", "", "", "", "", "",
        "", "", "", "", "", "",
        "", "", "", "", "", ""
    };

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [11:0] s_value = 12'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_symbol;
    logic        m_last;
    logic        m_out_of_range;

    // ------------------------------------------------------------------
    // Scoreboard state
    // ------------------------------------------------------------------
    roman_word_t numeral_due [$];   // characters still owed by the block
    int          mismatches   = 0;
    int          values_sent  = 0;
    int          zeros_sent   = 0;
    int          range_sent   = 0;
    int          words_seen   = 0;
    int          idle_cycles  = 0;
    int          burst_left   = 0;

    rx_mode_t    rx_mode      = RX_ALWAYS;
    int          rx_mode_left = 0;
    int          rx_phase     = 0;

    integer_to_roman_numeral_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_symbol       (m_symbol),
        .m_last         (m_last),
        .m_out_of_range (m_out_of_range)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: spell a value digit by digit, thousands first, and queue
    // one expected word per character. Anything past 3999 owes a single
    // error word with a zero symbol.
    // ------------------------------------------------------------------
    function automatic void spell_roman(input logic [11:0] v);
        logic [7:0]  chars [$];
        int unsigned digit;
        roman_word_t w;
        if (v > VALUE_LIMIT) begin
            w.symbol = 8'd0;
            w.last   = 1'b1;
            w.oor    = 1'b1;
            numeral_due.insert(numeral_due.size(), w);
            return;
        end
        for (int p = 3; p >= 0; p--) begin
            digit = (int'(v) / PLACE[p]) % 10;
            case (digit) inside
                1, 2, 3: begin
                    repeat (digit) chars.insert(chars.size(), UNIT_CODE[p]);
                end
                4: begin
                    chars.insert(chars.size(), UNIT_CODE[p]);
                    chars.insert(chars.size(), FIVE_CODE[p]);
                end
                5, 6, 7, 8: begin
                    chars.insert(chars.size(), FIVE_CODE[p]);
                    repeat (digit - 5) chars.insert(chars.size(), UNIT_CODE[p]);
                end
                9: begin
                    chars.insert(chars.size(), UNIT_CODE[p]);
                    chars.insert(chars.size(), TEN_CODE[p]);
                end
                default: ;
            endcase
        end
        // zero leaves chars empty: nothing owed
        for (int i = 0; i < chars.size(); i++) begin
            w.symbol = chars[i];
            w.last   = (i == chars.size() - 1);
            w.oor    = 1'b0;
            numeral_due.insert(numeral_due.size(), w);
        end
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Sender side. Payload changes at the falling edge; acceptance is seen
    // at the rising edge, where the expectation is queued straight away.
    // ------------------------------------------------------------------
    task automatic send_value(input logic [11:0] v, input row_kind_t kind,
                              input string text);
        roman_word_t w;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        values_sent++;
        if (v == 12'd0)
            zeros_sent++;
        if (v > VALUE_LIMIT)
            range_sent++;
        case (kind)
            ROW_TYPED: begin
                for (int i = 0; i < text.len(); i++) begin
                    w.symbol = text[i];
                    w.last   = (i == text.len() - 1);
                    w.oor    = 1'b0;
                    numeral_due.insert(numeral_due.size(), w);
                end
            end
            ROW_RANGE: begin
                w.symbol = 8'd0;
                w.last   = 1'b1;
                w.oor    = 1'b1;
                numeral_due.insert(numeral_due.size(), w);
            end
            default: spell_roman(v);
        endcase
    endtask

    // Bursts of random length with gaps of random length between them;
    // now and then a long run with no gap at all.
    task automatic pace_sender();
        int gap;
        int pick;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        pick = $urandom_range(0, 9);
        if (pick <= 5)
            gap = $urandom_range(1, 4);
        else if (pick <= 7)
            gap = $urandom_range(5, 12);
        else if (pick == 8)
            gap = $urandom_range(20, 40);
        else
            gap = 0;
        repeat (gap) @(negedge aclk) s_valid <= 1'b0;
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 12);
    endtask

    // Sender holds off until every owed word has been taken
    task automatic await_drain();
        @(negedge aclk) s_valid <= 1'b0;
        while (numeral_due.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: its own stall pattern, switching mode every so often
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(40, 160);
            end else begin
                rx_mode_left--;
            end
            rx_phase = (rx_phase + 1) % 3;
            case (rx_mode)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
                default:   m_ready <= (rx_phase == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Checker: every accepted word against the oldest owed one
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        roman_word_t want;
        if (aresetn && m_valid && m_ready) begin
            words_seen++;
            if (numeral_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word symbol=%02h last=%0b oor=%0b",
                                          m_symbol, m_last, m_out_of_range));
            end else begin
                want = numeral_due.pop_front();
                if (m_symbol !== want.symbol)
                    report_mismatch($sformatf("symbol %02h, expected %02h",
                                              m_symbol, want.symbol));
                if (m_last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              m_last, want.last));
                if (m_out_of_range !== want.oor)
                    report_mismatch($sformatf("out_of_range %0b, expected %0b",
                                              m_out_of_range, want.oor));
            end
        end
    end

    // Watchdog: too long with no handshake on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d words owed",
                     idle_cycles, numeral_due.size());
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [11:0] v;
        int          pick;
        int          th;
        int          hu;
        int          te;
        int          un;

        // synchronous reset, held for RESET_CYCLES rising edges, released on a falling edge
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_value(dir_value[r], dir_kind[r], dir_text[r]);
            pace_sender();
        end
        await_drain();

        // random part: mostly well-formed decimal values, with zeros,
        // out-of-range values and raw 12-bit noise mixed in
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                v = 12'd0;
            end else if (pick <= 2) begin
                v = 12'($urandom_range(4000, 4095));
            end else if (pick <= 4) begin
                v = 12'($urandom);
            end else if (pick == 5) begin
                // long numerals: digits that need the most characters
                th = 3;
                hu = ($urandom_range(0, 1) != 0) ? 8 : 7;
                te = ($urandom_range(0, 1) != 0) ? 8 : 3;
                un = ($urandom_range(0, 1) != 0) ? 8 : 7;
                v  = 12'(th * 1000 + hu * 100 + te * 10 + un);
            end else begin
                th = $urandom_range(0, 3);
                hu = $urandom_range(0, 9);
                te = $urandom_range(0, 9);
                un = $urandom_range(0, 9);
                v  = 12'(th * 1000 + hu * 100 + te * 10 + un);
            end
            send_value(v, ROW_MODEL, "");
            if ((n + 1) % DRAIN_EVERY == 0)
                await_drain();
            else
                pace_sender();
        end

        // wind down: everything owed must arrive, then a quiet spell in
        // case anything stray follows
        await_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d values (%0d zero, %0d above 3999); checked %0d words.",
                 values_sent, zeros_sent, range_sent, words_seen);
        $display("Receiver back-pressure varied between always-ready, sparse and beat modes.");
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
